### hdl/solg_pkg.sv
package solg_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int PIN_W     = 3;
    localparam int LATCH_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_SET_PIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLOSE_ALL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR_EMG = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ      = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAFE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELAY_OFF = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUS_FAIL  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_EN  = 2'd2;

    // Relay sits on port A, this pin
    localparam logic [PIN_W-1:0] RELAY_PIN = 3'd7;
    localparam logic             PORT_A    = 1'b0;

    typedef struct packed {
        logic [LATCH_W-1:0] allowed_pins_a;
        logic [LATCH_W-1:0] allowed_pins_b;
        logic               relay_enabled;
    } solg_cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              port_sel;
        logic [PIN_W-1:0]  pin_index;
        logic              drive_on;
        logic              fail_latch_a;
        logic              fail_latch_b;
        logic              fail_direction;
    } solg_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LATCH_W-1:0]  latch_a_now;
        logic [LATCH_W-1:0]  latch_b_now;
        logic                emergency_now;
        logic                relay_is_output;
    } solg_res_t;

endpackage

### hdl/solg_if.sv
// Command word channel
interface solg_cmd_if
    import solg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic              port_sel;
    logic [PIN_W-1:0]  pin_index;
    logic              drive_on;
    logic              fail_latch_a;
    logic              fail_latch_b;
    logic              fail_direction;

    modport source (
        output valid, func, port_sel, pin_index, drive_on,
               fail_latch_a, fail_latch_b, fail_direction,
        input  ready
    );
    modport sink (
        input  valid, func, port_sel, pin_index, drive_on,
               fail_latch_a, fail_latch_b, fail_direction,
        output ready
    );
endinterface

// Result word channel
interface solg_res_if
    import solg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LATCH_W-1:0]  latch_a_now;
    logic [LATCH_W-1:0]  latch_b_now;
    logic                emergency_now;
    logic                relay_is_output;

    modport source (
        output valid, status, latch_a_now, latch_b_now, emergency_now, relay_is_output,
        input  ready
    );
    modport sink (
        input  valid, status, latch_a_now, latch_b_now, emergency_now, relay_is_output,
        output ready
    );
endinterface

### hdl/solg_cfg_regs.sv
module solg_cfg_regs
    import solg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output solg_cfg_t             cfg
);

    solg_cfg_t cfg_reg;
    solg_cfg_t cfg_next;

    // Decode register writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALLOWED_A: cfg_next.allowed_pins_a = cfg_wdata[LATCH_W-1:0];
                CFG_ALLOWED_B: cfg_next.allowed_pins_b = cfg_wdata[LATCH_W-1:0];
                CFG_RELAY_EN:  cfg_next.relay_enabled  = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/solg_core.sv
module solg_core
    import solg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  solg_cmd_t cmd,
    input  solg_cfg_t cfg,
    output solg_res_t res
);

    logic [LATCH_W-1:0]  latch_a_reg, latch_a_next;
    logic [LATCH_W-1:0]  latch_b_reg, latch_b_next;
    logic                emergency_reg, emergency_next;
    logic                relay_dir_reg, relay_dir_next;
    logic [STATUS_W-1:0] status;

    logic [LATCH_W-1:0]  pin_bit;
    logic [LATCH_W-1:0]  port_mask;
    logic [LATCH_W-1:0]  port_shadow;
    logic [LATCH_W-1:0]  shadow_new;
    logic                port_fail;
    logic                relay_on_req;

    // Operand selection for set-pin
    always_comb
    begin
        pin_bit      = LATCH_W'(1) << cmd.pin_index;
        port_mask    = cmd.port_sel ? cfg.allowed_pins_b : cfg.allowed_pins_a;
        port_shadow  = cmd.port_sel ? latch_b_reg : latch_a_reg;
        port_fail    = cmd.port_sel ? cmd.fail_latch_b : cmd.fail_latch_a;
        shadow_new   = cmd.drive_on ? (port_shadow | pin_bit) : (port_shadow & ~pin_bit);
        relay_on_req = (cmd.port_sel == PORT_A) && (cmd.pin_index == RELAY_PIN)
                       && cmd.drive_on;
    end

    // Command evaluation
    always_comb
    begin
        latch_a_next   = latch_a_reg;
        latch_b_next   = latch_b_reg;
        emergency_next = emergency_reg;
        relay_dir_next = relay_dir_reg;
        status         = ST_OK;
        case (cmd.func)
            FN_SET_PIN:
            begin
                if ((port_mask & pin_bit) == '0)
                begin
                    status = ST_NOT_ALLOW;
                end
                else if (emergency_reg && cmd.drive_on)
                begin
                    status = ST_UNSAFE;
                end
                else if (relay_on_req && !cfg.relay_enabled)
                begin
                    status = ST_RELAY_OFF;
                end
                else if (relay_on_req && cmd.fail_direction)
                begin
                    status = ST_BUS_FAIL;
                end
                else
                begin
                    // direction goes to output in the same update as the latch write, even if that write fails
                    if (relay_on_req)
                    begin
                        relay_dir_next = 1'b1;
                    end
                    if (shadow_new != port_shadow)
                    begin
                        if (port_fail)
                        begin
                            status = ST_BUS_FAIL;
                        end
                        else if (cmd.port_sel)
                        begin
                            latch_b_next = shadow_new;
                        end
                        else
                        begin
                            latch_a_next = shadow_new;
                        end
                    end
                end
            end
            FN_CLOSE_ALL:
            begin
                if (!cmd.fail_latch_a)
                begin
                    latch_a_next = '0;
                end
                if (!cmd.fail_latch_b)
                begin
                    latch_b_next = '0;
                end
                if (cfg.relay_enabled && !cmd.fail_direction)
                begin
                    relay_dir_next = 1'b0;
                end
                emergency_next = 1'b1;
                if (cmd.fail_latch_a || cmd.fail_latch_b
                    || (cfg.relay_enabled && cmd.fail_direction))
                begin
                    status = ST_BUS_FAIL;
                end
            end
            FN_CLEAR_EMG:
            begin
                if ((latch_a_reg != '0) || (latch_b_reg != '0))
                begin
                    status = ST_UNSAFE;
                end
                else
                begin
                    emergency_next = 1'b0;
                end
            end
            FN_READ:
            begin
                status = ST_OK;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // State registers, updated once per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_a_reg   <= '0;
            latch_b_reg   <= '0;
            emergency_reg <= 1'b0;
            relay_dir_reg <= 1'b0;
        end
        else if (fire)
        begin
            latch_a_reg   <= latch_a_next;
            latch_b_reg   <= latch_b_next;
            emergency_reg <= emergency_next;
            relay_dir_reg <= relay_dir_next;
        end
    end

    // Result shows the state after the command
    always_comb
    begin
        res.status          = status;
        res.latch_a_now     = latch_a_next;
        res.latch_b_now     = latch_b_next;
        res.emergency_now   = emergency_next;
        res.relay_is_output = relay_dir_next;
    end

    // Close-all always latches the emergency
    a_close_sets_emg: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.func == FN_CLOSE_ALL) |=> emergency_reg)
        else $error("close-all did not set emergency latch");

    // Emergency only gets set by close-all
    a_emg_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(emergency_reg) |-> $past(fire && (cmd.func == FN_CLOSE_ALL)))
        else $error("emergency latch set without close-all");

    // No latch bit turns on while the emergency is latched
    a_no_on_in_emg: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emergency_reg |=>
            ((latch_a_reg & ~$past(latch_a_reg)) == '0)
            && ((latch_b_reg & ~$past(latch_b_reg)) == '0))
        else $error("latch bit turned on during emergency");

    // Relay direction goes to output only when the relay is fitted
    a_relay_dir_gate: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(relay_dir_reg) |-> $past(cfg.relay_enabled))
        else $error("relay driven as output while disabled");

endmodule

### hdl/safe_output_latch_gate_top.sv
// Safety gate for two 8-bit output latch shadows (ports A and B) plus the
// direction of the relay pin on port A pin 7. Each command word (set pin,
// close all, clear emergency, read state) yields exactly one result word
// carrying the status and the state after the command. The block takes one
// command per cycle when the result side is not stalled: a command is
// registered on input, evaluated by the gate logic against the state
// registers and placed in the output register, where its result is offered
// until it is taken. Input and output registers hold up to two commands:
// while a result waits to be taken, one more command is accepted and then
// the input stalls until the result moves. Configuration registers (pin
// whitelists, relay enable) are written through cfg_we/cfg_index/cfg_wdata
// and should only change while idle.
module safe_output_latch_gate_top
    import solg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    solg_cmd_if.sink              cmd,
    solg_res_if.source            res
);

    solg_cfg_t cfg;
    solg_cmd_t cmd_reg;
    solg_res_t core_res;
    solg_res_t res_reg;
    logic      cmd_valid_reg;
    logic      res_valid_reg;
    logic      advance;
    logic      fire;

    solg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    solg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // Pipeline flow control
    assign advance   = !res_valid_reg || res.ready;
    assign fire      = cmd_valid_reg && advance;
    assign cmd.ready = !cmd_valid_reg || advance;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg <= cmd_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.func           <= cmd.func;
            cmd_reg.port_sel       <= cmd.port_sel;
            cmd_reg.pin_index      <= cmd.pin_index;
            cmd_reg.drive_on       <= cmd.drive_on;
            cmd_reg.fail_latch_a   <= cmd.fail_latch_a;
            cmd_reg.fail_latch_b   <= cmd.fail_latch_b;
            cmd_reg.fail_direction <= cmd.fail_direction;
        end
        if (fire)
        begin
            res_reg <= core_res;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.status          = res_reg.status;
    assign res.latch_a_now     = res_reg.latch_a_now;
    assign res.latch_b_now     = res_reg.latch_b_now;
    assign res.emergency_now   = res_reg.emergency_now;
    assign res.relay_is_output = res_reg.relay_is_output;

    // A result waiting on the output must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !fire)
        else $error("result overwritten while stalled");

    // A command held in the input stage moves on once the output frees up
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && res.ready |-> fire)
        else $error("pending command not advanced");

    // Reported status code is within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.status == ST_OK) || (res_reg.status == ST_NOT_ALLOW)
            || (res_reg.status == ST_UNSAFE) || (res_reg.status == ST_RELAY_OFF)
            || (res_reg.status == ST_BUS_FAIL))
        else $error("undefined status code");

endmodule
